[rtl/ols_pkg.sv]
// ols_pkg: shared constants, operation and status codes, and the cell control
// type for the ordered list store. No dependencies.
package ols_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 3;
  localparam int POS_W      = 4;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int LEN_W      = CNT_W;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BEYOND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  // Per-cell load select; load wins over take_prev, take_prev over take_next.
  typedef struct packed {
    logic load;
    logic take_prev;
    logic take_next;
  } ols_cell_ctl_t;

endpackage

[rtl/ols_if.sv]
// ols_if: valid/ready channel interfaces for the input word and result word
// of the ordered list store. Depends on ols_pkg.
interface ols_in_if import ols_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, op, value, position, input ready);
  modport sink   (input valid, op, value, position, output ready);
endinterface

interface ols_out_if import ols_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data_out;
  logic [LEN_W-1:0]         length;
  logic                     last;

  modport source (output valid, status, data_out, length, last, input ready);
  modport sink   (input valid, status, data_out, length, last, output ready);
endinterface

[rtl/ols_cell.sv]
// ols_cell: one storage cell of the list chain; loads a new value or takes
// the value of a neighbor. Depends on ols_pkg.
module ols_cell import ols_pkg::*; (
  input  logic                     clk,
  input  ols_cell_ctl_t            ctl,
  input  logic signed [DATA_W-1:0] in_val,
  input  logic signed [DATA_W-1:0] prev_val,
  input  logic signed [DATA_W-1:0] next_val,
  output logic signed [DATA_W-1:0] val_r
);

  logic signed [DATA_W-1:0] val_nxt;

  always_comb begin
    if (ctl.load) begin
      val_nxt = in_val;
    end else if (ctl.take_prev) begin
      val_nxt = prev_val;
    end else if (ctl.take_next) begin
      val_nxt = next_val;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[rtl/ordered_list_store.sv]
// ordered_list_store: top level; a chain of shifting cells holds the list head
// to tail, a small controller runs the operations. Depends on ols_pkg, ols_if, ols_cell.
//
//   channel | dir | words per item             | fields
//   --------+-----+----------------------------+-----------------------------------
//   in_ch   | in  | 1                          | op, value, position
//   out_ch  | out | 1, or count for a read all | status, data_out, length, last
//
// Operations: for append, insert and delete each cell holds, loads, shifts back
// or shifts forward in the same edge. A read all emits one word per element:
// the chain rotates toward the head once per emitted word and holds while the
// result is stalled, so after count rotations the list is back in place.
// Reset: clears the count, the controller and the output valid; cell contents
// are left as they are, since only cells below the count are ever read.
// Stalls: a full result register holds while out_ch.ready is low; in_ch.ready
// drops while that register is full and not taken, and during a read all.
module ordered_list_store import ols_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ols_in_if.sink    in_ch,
  ols_out_if.source out_ch
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         rd_left_r, rd_left_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [LEN_W-1:0]         out_len_r, out_len_nxt;
  logic                     out_last_r, out_last_nxt;

  logic out_free, in_ready, fire_in, full, empty;
  logic do_append, do_insert, do_delete, rot_en;

  logic signed [DATA_W-1:0] cell_val [LIST_DEPTH];
  logic signed [DATA_W-1:0] prev_val [LIST_DEPTH];
  logic signed [DATA_W-1:0] next_val [LIST_DEPTH];
  ols_cell_ctl_t            cell_ctl [LIST_DEPTH];

  // The result register may be reloaded when empty or when taken this cycle.
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign fire_in  = in_ch.valid && in_ready;
  assign full     = (cnt_r == CNT_W'(LIST_DEPTH));
  assign empty    = (cnt_r == '0);

  // Controller: decode the word, pick the cell action, build the result.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_left_nxt    = rd_left_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    do_append      = 1'b0;
    do_insert      = 1'b0;
    do_delete      = 1'b0;
    rot_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (fire_in) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = '0;
          out_last_nxt   = 1'b1;
          unique case (in_ch.op)
            OP_APPEND: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                do_append = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            OP_INSERT: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                do_insert = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            OP_DELETE: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else if (CMP_W'(in_ch.position) >= CMP_W'(cnt_r)) begin
                out_status_nxt = ST_BEYOND;
              end else begin
                do_delete = 1'b1;
                cnt_nxt   = cnt_r - 1'b1;
              end
            end
            OP_READ: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                // Emit the head now and rotate; the rest follow one per cycle unless stalled.
                rot_en       = 1'b1;
                out_data_nxt = cell_val[0];
                out_last_nxt = (cnt_r == CNT_W'(1));
                rd_left_nxt  = cnt_r - 1'b1;
                if (cnt_r != CNT_W'(1)) begin
                  state_nxt = S_READ;
                end
              end
            end
            default: begin
              // Count and unused codes: report the length, change nothing.
            end
          endcase
          out_len_nxt = LEN_W'(cnt_nxt);
        end
      end
      S_READ: begin
        if (out_free) begin
          rot_en         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = cell_val[0];
          out_len_nxt    = LEN_W'(cnt_r);
          out_last_nxt   = (rd_left_r == CNT_W'(1));
          rd_left_nxt    = rd_left_r - 1'b1;
          if (rd_left_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Cell chain. Each cell sees its back neighbor (insert shift), its front
  // neighbor (delete shift and rotate) and the incoming value. On a rotate the
  // head value wraps around into the last occupied cell.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_val[i] = in_ch.value;
    end else begin : g_body
      assign prev_val[i] = cell_val[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign next_val[i] = cell_val[0];
    end else begin : g_mid
      assign next_val[i] = (cnt_r == CNT_W'(i + 1)) ? cell_val[0] : cell_val[i+1];
    end

    always_comb begin
      cell_ctl[i].load      = (do_append && (cnt_r == CNT_W'(i))) ||
                              (do_insert && (i == 0));
      cell_ctl[i].take_prev = do_insert && (i != 0);
      cell_ctl[i].take_next = rot_en ||
                              (do_delete && (CMP_W'(i) >= CMP_W'(in_ch.position)));
    end

    ols_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .in_val   (in_ch.value),
      .prev_val (prev_val[i]),
      .next_val (next_val[i]),
      .val_r    (cell_val[i])
    );
  end

  // Hold state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rd_left_r    <= rd_left_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_len_r    <= out_len_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.length   = out_len_r;
  assign out_ch.last     = out_last_r;

endmodule

[rtl/ols_chk.sv]
// ols_chk: port-level checker for ordered_list_store, attached by bind.
// Depends on ols_pkg and the top level's channel interfaces.
module ols_chk import ols_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STAT_W-1:0]        out_status,
  input logic signed [DATA_W-1:0] out_data_out,
  input logic [LEN_W-1:0]         out_length,
  input logic                     out_last
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_data_out) && $stable(out_length) && $stable(out_last))
    else $error("result word changed while stalled");

  // Inside a read-all run: status ok and no new input taken.
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready && (out_status == ST_OK))
    else $error("input accepted or bad status inside read-all run");

  // A taken non-final word is followed at once by the next one.
  a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("read-all run broken");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_length == LEN_W'(LIST_DEPTH)))
    else $error("full status with length below depth");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_length == '0) && (out_data_out == '0))
    else $error("empty status with nonzero length or data");

endmodule

bind ordered_list_store ols_chk u_ols_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_data_out (out_ch.data_out),
  .out_length   (out_ch.length),
  .out_last     (out_ch.last)
);

[tb/sv/tb.sv]
// tb: self-checking bench for ordered_list_store; drives list operations and
// checks every result word against an in-bench list model or a directed row.
// Depends on ols_pkg, ols_if and the ordered_list_store RTL.
module tb import ols_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Op codes 5..7 have no meaning; the block answers them like a count.
  localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam int IDLE_PCT     = 14;
  localparam int RANDOM_WORDS = 128;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 8;
  localparam int NUM_ROWS     = 21;

  // One result word as the list model predicts it.
  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } list_result_t;

  // One directed row: issue the op reps times (value counts up per repeat).
  // Where typed is set, the single result word is spelled out right here.
  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    int                       reps;
    bit                       typed;
    logic [STAT_W-1:0]        exp_status;
    logic [LEN_W-1:0]         exp_length;
  } list_step_t;

  logic clk;
  logic rst_n;
  bit   steady_flow;
  int   mismatches;
  int   quiet_cycles;

  // Model of the list contents, head at index 0, and its length.
  logic signed [DATA_W-1:0] list_cells [LIST_DEPTH];
  int                       list_len;
  list_result_t             awaited_results[$];

  ols_in_if  in_ch();
  ols_out_if out_ch();

  ordered_list_store u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Directed opening: empty-list cases, the value extremes, every op and the
  // unused codes, fill, full-list appends and inserts, head/middle/tail deletes.
  list_step_t directed_rows [NUM_ROWS] = '{
    '{OP_READ,   32'sd0,           4'd0,  1, 1'b1, ST_EMPTY,  5'd0},
    '{OP_DELETE, 32'sd0,           4'd0,  1, 1'b1, ST_EMPTY,  5'd0},
    '{OP_COUNT,  32'sd0,           4'd0,  1, 1'b1, ST_OK,     5'd0},
    '{OP_SPARE7, 32'sd0,           4'd0,  1, 1'b1, ST_OK,     5'd0},
    '{OP_APPEND, 32'sh7FFF_FFFF,   4'd0,  1, 1'b1, ST_OK,     5'd1},
    '{OP_INSERT, 32'sh8000_0000,   4'd15, 1, 1'b1, ST_OK,     5'd2},
    '{OP_SPARE5, 32'sd0,           4'd0,  1, 1'b1, ST_OK,     5'd2},
    '{OP_SPARE6, 32'sd0,           4'd0,  1, 1'b1, ST_OK,     5'd2},
    '{OP_DELETE, 32'sd0,           4'd2,  1, 1'b1, ST_BEYOND, 5'd2},
    '{OP_DELETE, 32'sd0,           4'd15, 1, 1'b1, ST_BEYOND, 5'd2},
    '{OP_READ,   32'sd0,           4'd0,  1, 1'b0, ST_OK,     5'd0},
    '{OP_APPEND, 32'sd0,           4'd0,  7, 1'b0, ST_OK,     5'd0},
    '{OP_INSERT, -32'sd1,          4'd0,  7, 1'b0, ST_OK,     5'd0},
    '{OP_APPEND, 32'sh5A5A_5A5A,   4'd0,  1, 1'b1, ST_FULL,   5'd16},
    '{OP_INSERT, 32'shA5A5_A5A5,   4'd0,  1, 1'b1, ST_FULL,   5'd16},
    '{OP_COUNT,  32'sd0,           4'd0,  1, 1'b1, ST_OK,     5'd16},
    '{OP_READ,   32'sd0,           4'd0,  1, 1'b0, ST_OK,     5'd0},
    '{OP_DELETE, 32'sd0,           4'd15, 1, 1'b1, ST_OK,     5'd15},
    '{OP_DELETE, 32'sd0,           4'd0,  1, 1'b1, ST_OK,     5'd14},
    '{OP_DELETE, 32'sd0,           4'd7,  1, 1'b1, ST_OK,     5'd13},
    '{OP_READ,   32'sd0,           4'd0,  1, 1'b0, ST_OK,     5'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the list model by one accepted word. With queue_results set,
  // push the result words it causes; otherwise only update the state.
  task automatic apply_list_op(input logic [OP_W-1:0] op,
                               input logic signed [DATA_W-1:0] value,
                               input logic [POS_W-1:0] position,
                               input bit queue_results);
    list_result_t res;
    res.status = ST_OK;
    res.data   = '0;
    res.last   = 1'b1;
    case (op)
      OP_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_cells[list_len] = value;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_cells[i] = list_cells[i-1];
          list_cells[0] = value;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (int'(position) >= list_len) begin
          res.status = ST_BEYOND;
        end else begin
          for (int i = int'(position); i + 1 < list_len; i++)
            list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (list_len == 0) res.status = ST_EMPTY;
      end
      default: ;
    endcase
    res.length = LEN_W'(list_len);
    if (queue_results) begin
      if (op == OP_READ && list_len > 0) begin
        // Read all: one word per element, head first, last flags the tail.
        for (int i = 0; i < list_len; i++)
          awaited_results.push_back('{ST_OK, list_cells[i], LEN_W'(list_len),
                                      (i == list_len - 1)});
      end else begin
        awaited_results.push_back(res);
      end
    end
  endtask

  // Offer one input word and hold it until the block takes it. Drop valid
  // for one cycle at random first, unless the steady stretch is running.
  task automatic send_word(input logic [OP_W-1:0] op,
                           input logic signed [DATA_W-1:0] value,
                           input logic [POS_W-1:0] position);
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.value    <= value;
    in_ch.position <= position;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stimulus: reset, the directed rows, then random words.
  initial begin
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    bit                       grow;
    int                       add_pct;
    int                       roll;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = '0;
    in_ch.value    = '0;
    in_ch.position = '0;
    out_ch.ready   = 1'b0;
    steady_flow    = 1'b0;
    mismatches     = 0;
    list_len       = 0;
    grow           = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        value = directed_rows[r].value + k;
        send_word(directed_rows[r].op, value, directed_rows[r].position);
        apply_list_op(directed_rows[r].op, value, directed_rows[r].position,
                      !directed_rows[r].typed);
        if (directed_rows[r].typed)
          awaited_results.push_back('{directed_rows[r].exp_status, '0,
                                      directed_rows[r].exp_length, 1'b1});
      end
    end

    // Random words. Swing the list between empty and full so that both
    // ends get hit: grow mode favors appends and inserts, shrink mode deletes.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady_flow <= (n >= 60 && n < 110);
      if (list_len >= LIST_DEPTH) grow = 1'b0;
      else if (list_len == 0) grow = 1'b1;
      else if ($urandom_range(0, 19) == 0) grow = !grow;

      add_pct = grow ? 30 : 8;
      roll    = $urandom_range(0, 99);
      if (roll < add_pct) op = OP_APPEND;
      else if (roll < 2 * add_pct) op = OP_INSERT;
      else if (roll < 80) op = OP_DELETE;
      else if (roll < 88) op = OP_COUNT;
      else if (roll < 96) op = OP_READ;
      else begin
        case ($urandom_range(0, 2))
          0:       op = OP_SPARE5;
          1:       op = OP_SPARE6;
          default: op = OP_SPARE7;
        endcase
      end

      case ($urandom_range(0, 11))
        0:       value = 32'sh7FFF_FFFF;
        1:       value = 32'sh8000_0000;
        2:       value = -32'sd1;
        default: value = $urandom;
      endcase

      // Mostly a position inside the list, sometimes any 4-bit position.
      if (list_len > 0 && $urandom_range(0, 3) != 0)
        position = POS_W'($urandom_range(0, list_len - 1));
      else
        position = POS_W'($urandom_range(0, 15));

      send_word(op, value, position);
      apply_list_op(op, value, position, 1'b1);
    end
    in_ch.valid <= 1'b0;
    steady_flow <= 1'b0;

    // Drain: wait for the last expected word, then watch for strays.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: stall at random, hold ready high during the steady stretch.
  always @(posedge clk) begin
    if (steady_flow) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Check every accepted result word against the oldest expectation.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result word: status %0d data_out %0d length %0d last %0d",
               out_ch.status, out_ch.data_out, out_ch.length, out_ch.last);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          mismatches++;
        end
        if (out_ch.data_out !== want.data) begin
          $error("data_out: expected %0d, got %0d", want.data, out_ch.data_out);
          mismatches++;
        end
        if (out_ch.length !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, out_ch.length);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
